// File: rtl/core/rdft_pkg.sv
// Shared types, constants and the twiddle table of the direct real-input DFT engine.
// Used by the loader, queue and engine modules of the block and by the top level.
// No dependencies.
`timescale 1ns / 1ps

package rdft_pkg;

    // Frame and datapath sizes
    localparam int FRAME_LENGTH = 64;
    localparam int IDX_W        = $clog2(FRAME_LENGTH);
    localparam int SAMPLE_W     = 16;
    localparam int STORE_DEPTH  = 2 * FRAME_LENGTH;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int PROD_W       = 2 * SAMPLE_W;
    localparam int ACC_W        = 40;
    localparam int SCALE_SH     = IDX_W + 15;
    localparam int OUT_DATA_W   = 2 * SAMPLE_W;

    // Frame token queue between loader and engine
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LENGTH - 1);

    // Fixed-point constants of the twiddle generator (Q2.30)
    localparam longint PI_Q30  = 64'sd3373259426;
    localparam longint ONE_Q30 = 64'sd1073741824;
    localparam longint Q15_MAX = 64'sd32767;
    localparam longint Q15_MIN = -64'sd32768;

    // Taylor term divisors for sine and cosine
    localparam longint SIN_DIV [1:8] = '{6, 20, 42, 72, 110, 156, 210, 272};
    localparam longint COS_DIV [1:8] = '{2, 12, 30, 56, 90, 132, 182, 240};

    typedef logic signed [SAMPLE_W-1:0] t_coef;

    typedef struct packed {
        t_coef cos_v;
        t_coef sin_v;
    } t_twid;

    typedef t_twid [FRAME_LENGTH-1:0] t_twid_tab;

    // Sample store write request from the loader
    typedef struct packed {
        logic                en;
        logic [ADDR_W-1:0]   addr;
        logic [SAMPLE_W-1:0] data;
    } t_ram_wr;

    // Sample store read request from the engine
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_ram_rd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_DRAIN
    } t_back_state;

    // Round a Q30 value to Q1.15, halves upward, then saturate
    function automatic longint q30_to_q15(longint v);
        longint biased;
        longint r;
        biased = v + 64'sd16384 + (64'sd1 <<< 40);
        if (biased < 0) begin
            biased = 0;
        end
        r = (biased >>> 15) - (64'sd1 <<< 25);
        if (r > Q15_MAX) begin
            r = Q15_MAX;
        end
        if (r < Q15_MIN) begin
            r = Q15_MIN;
        end
        return r;
    endfunction

    // Build the cosine/sine table over one turn, evaluated at elaboration
    function automatic t_twid_tab build_twid_tab();
        t_twid_tab tab;
        longint    a4;
        longint    quad;
        longint    rem;
        longint    x;
        longint    x2;
        longint    st;
        longint    ss;
        longint    ct;
        longint    cs;
        longint    c;
        longint    s;
        for (int m = 0; m < FRAME_LENGTH; m++) begin
            a4   = 4 * longint'(m);
            quad = (a4 / FRAME_LENGTH) & 3;
            rem  = a4 % FRAME_LENGTH;
            x    = (rem * PI_Q30 + FRAME_LENGTH) / (2 * FRAME_LENGTH);
            x2   = (x * x) >>> 30;
            st   = x;
            ss   = x;
            ct   = ONE_Q30;
            cs   = ONE_Q30;
            for (int i = 1; i <= 8; i++) begin
                st = ((st * x2) >>> 30) / SIN_DIV[i];
                ct = ((ct * x2) >>> 30) / COS_DIV[i];
                if ((i % 2) == 1) begin
                    ss = ss - st;
                    cs = cs - ct;
                end else begin
                    ss = ss + st;
                    cs = cs + ct;
                end
            end
            c = q30_to_q15(cs);
            s = q30_to_q15(ss);
            case (quad)
                0: begin
                    tab[m].cos_v = SAMPLE_W'(c);
                    tab[m].sin_v = SAMPLE_W'(s);
                end
                1: begin
                    tab[m].cos_v = SAMPLE_W'(-s);
                    tab[m].sin_v = SAMPLE_W'(c);
                end
                2: begin
                    tab[m].cos_v = SAMPLE_W'(-c);
                    tab[m].sin_v = SAMPLE_W'(-s);
                end
                default: begin
                    tab[m].cos_v = SAMPLE_W'(s);
                    tab[m].sin_v = SAMPLE_W'(-c);
                end
            endcase
        end
        return tab;
    endfunction

    localparam t_twid_tab TWID_TAB = build_twid_tab();

endpackage

// File: rtl/core/rdft_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps

module rdft_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/rdft_front.sv
// Sample loader: accepts samples into the current store bank and marks frame ends.
// Depends on rdft_pkg.
`timescale 1ns / 1ps

module rdft_front
    import rdft_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_valid,
    output logic                o_s_ready,
    input  logic [SAMPLE_W-1:0] i_s_data,
    input  logic                i_q_full,
    output t_ram_wr             o_wr,
    output logic                o_push,
    output logic                o_push_tok
);

    logic             r_bank;
    logic             n_bank;
    logic [IDX_W-1:0] r_cnt;
    logic [IDX_W-1:0] n_cnt;
    logic             w_accept;
    logic             w_frame_end;

    // Hold off while both banks are owned by the engine
    assign o_s_ready   = !i_q_full;
    assign w_accept    = i_s_valid && !i_q_full;
    assign w_frame_end = (r_cnt == LAST_IDX);

    // Write each accepted sample into the bank being filled
    always_comb begin
        o_wr.en    = w_accept;
        o_wr.addr  = {r_bank, r_cnt};
        o_wr.data  = i_s_data;
        o_push     = w_accept && w_frame_end;
        o_push_tok = r_bank;
    end

    // Advance the fill position; swap banks at the end of a frame
    always_comb begin
        n_cnt  = r_cnt;
        n_bank = r_bank;
        if (w_accept) begin
            if (w_frame_end) begin
                n_cnt  = '0;
                n_bank = ~r_bank;
            end else begin
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_bank <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_bank <= n_bank;
        end
    end

endmodule

// File: rtl/core/rdft_queue.sv
// Two-entry queue of full-frame tokens (store bank) between loader and engine.
// Depends on rdft_pkg.
`timescale 1ns / 1ps

module rdft_queue
    import rdft_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  logic i_push_tok,
    output logic o_full,
    output logic o_valid,
    output logic o_head,
    input  logic i_pop
);

    logic              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic [QCNT_W-1:0] n_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_slot[r_rp];

    // Track occupancy across simultaneous push and pop
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // Store tokens
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_push_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/rdft_back.sv
// Transform engine: one complex multiply-accumulate per cycle over a stored frame,
// bin by bin, with a result hold stage and an output register. Depends on rdft_pkg.
`timescale 1ns / 1ps

module rdft_back
    import rdft_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_tok_valid,
    input  logic                  i_tok,
    output logic                  o_tok_pop,
    output t_ram_rd               o_rd,
    input  logic [SAMPLE_W-1:0]   i_rd_data,
    output logic                  o_m_valid,
    input  logic                  i_m_ready,
    output logic [OUT_DATA_W-1:0] o_m_data,
    output logic [IDX_W-1:0]      o_m_bin,
    output logic                  o_m_last
);

    t_back_state r_state;
    t_back_state n_state;
    logic [IDX_W-1:0] r_k;
    logic [IDX_W-1:0] n_k;
    logic [IDX_W-1:0] r_n;
    logic [IDX_W-1:0] n_n;
    logic [IDX_W-1:0] r_m;
    logic [IDX_W-1:0] n_m;
    logic             w_issue;

    // Pipeline stage 1: sample read and twiddle
    logic  r_v1;
    logic  r_last1;
    t_coef r_cos1;
    t_coef r_sin1;

    // Pipeline stage 2: products
    logic                     r_v2;
    logic                     r_last2;
    logic signed [PROD_W-1:0] r_pre;
    logic signed [PROD_W-1:0] r_pim;

    // Accumulators and hold stage
    logic signed [ACC_W-1:0] r_acc_re;
    logic signed [ACC_W-1:0] r_acc_im;
    logic signed [ACC_W-1:0] w_sum_re;
    logic signed [ACC_W-1:0] w_sum_im;
    logic                    r_fin_v;
    logic signed [ACC_W-1:0] r_fin_re;
    logic signed [ACC_W-1:0] r_fin_im;
    logic [IDX_W-1:0]        r_fin_k;

    // Output register
    logic             r_out_v;
    t_coef            r_out_re;
    t_coef            r_out_im;
    logic [IDX_W-1:0] r_out_k;
    logic             w_move;
    logic             w_pipe_empty;

    // Divide by the frame scale toward minus infinity, then saturate
    function automatic t_coef scale_down(logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] sh;
        sh = v >>> SCALE_SH;
        if (sh > ACC_W'(Q15_MAX)) begin
            return t_coef'(Q15_MAX);
        end else if (sh < ACC_W'(Q15_MIN)) begin
            return t_coef'(Q15_MIN);
        end else begin
            return sh[SAMPLE_W-1:0];
        end
    endfunction

    assign w_pipe_empty = !r_v1 && !r_v2 && !r_fin_v;

    // Sequencer: next state, counters and read request
    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_n       = r_n;
        n_m       = r_m;
        w_issue   = 1'b0;
        o_tok_pop = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_tok_valid) begin
                    n_state = BK_RUN;
                    n_n     = '0;
                    n_m     = '0;
                end
            end
            BK_RUN: begin
                w_issue = 1'b1;
                n_n     = r_n + 1'b1;
                n_m     = r_m + r_k;
                if (r_n == LAST_IDX) begin
                    n_state = BK_DRAIN;
                    // Release the bank once its last sample has been read
                    if (r_k == LAST_IDX) begin
                        o_tok_pop = 1'b1;
                    end
                end
            end
            BK_DRAIN: begin
                if (w_pipe_empty) begin
                    n_n = '0;
                    n_m = '0;
                    if (r_k == LAST_IDX) begin
                        n_k     = '0;
                        n_state = BK_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = BK_RUN;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
        o_rd.en   = w_issue;
        o_rd.addr = {i_tok, r_n};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_k     <= '0;
            r_n     <= '0;
            r_m     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_n     <= n_n;
            r_m     <= n_m;
        end
    end

    // Stage 1: look up the twiddle beside the sample read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= w_issue;
        end
        r_last1 <= (r_n == LAST_IDX);
        r_cos1  <= TWID_TAB[r_m].cos_v;
        r_sin1  <= TWID_TAB[r_m].sin_v;
    end

    // Stage 2: multiply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_last2 <= r_last1;
        r_pre   <= $signed(i_rd_data) * r_cos1;
        r_pim   <= $signed(i_rd_data) * r_sin1;
    end

    // Stage 3: accumulate; real adds x*cos, imaginary subtracts x*sin
    assign w_sum_re = r_acc_re + {{(ACC_W-PROD_W){r_pre[PROD_W-1]}}, r_pre};
    assign w_sum_im = r_acc_im - {{(ACC_W-PROD_W){r_pim[PROD_W-1]}}, r_pim};

    assign w_move = r_fin_v && (!r_out_v || i_m_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
            r_fin_v  <= 1'b0;
        end else begin
            if (r_v2) begin
                if (r_last2) begin
                    r_acc_re <= '0;
                    r_acc_im <= '0;
                end else begin
                    r_acc_re <= w_sum_re;
                    r_acc_im <= w_sum_im;
                end
            end
            r_fin_v <= (r_fin_v && !w_move) || (r_v2 && r_last2);
        end
        if (r_v2 && r_last2) begin
            r_fin_re <= w_sum_re;
            r_fin_im <= w_sum_im;
            r_fin_k  <= r_k;
        end
    end

    // Output register: scale the held sums on the way in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_move) begin
            r_out_v <= 1'b1;
        end else if (i_m_ready) begin
            r_out_v <= 1'b0;
        end
        if (w_move) begin
            r_out_re <= scale_down(r_fin_re);
            r_out_im <= scale_down(r_fin_im);
            r_out_k  <= r_fin_k;
        end
    end

    assign o_m_valid = r_out_v;
    assign o_m_data  = {r_out_im, r_out_re};
    assign o_m_bin   = r_out_k;
    assign o_m_last  = (r_out_k == LAST_IDX);

endmodule

// File: rtl/core/real_dft_engine.sv
// Top level of the direct real-input DFT engine: loader, frame queue, engine, store.
// Depends on rdft_pkg, rdft_ram, rdft_front, rdft_queue and rdft_back.
`timescale 1ns / 1ps

// Takes frames of 64 signed 16-bit samples, one per accepted request, and for each
// frame returns 64 requests, one per bin k in order, carrying (1/64) times the DFT
// sum with the usual negative exponent: real part in tdata[15:0], imaginary part in
// tdata[31:16], k in tuser and tlast on bin 63. The sample store holds two frames,
// so a new frame loads at one sample per cycle while the previous one is being
// transformed; the loader stalls only when both banks are waiting for the engine.
// The engine has one complex multiply-accumulate fed by one read port of the store,
// so each bin is worked out as 64 reads followed by a pipeline drain and hand-off of
// its result, one bin after another; a new bin starts only after the previous one
// has left the hold stage.
module real_dft_engine
    import rdft_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [SAMPLE_W-1:0]   s_axis_tdata,   // [15:0] sample
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [15:0] real_part, [31:16] imag_part
    output logic [IDX_W-1:0]      m_axis_tuser,   // [5:0] bin_index
    output logic                  m_axis_tlast
);

    t_ram_wr             w_wr;
    t_ram_rd             w_rd;
    logic [SAMPLE_W-1:0] w_rd_data;
    logic                w_push;
    logic                w_push_tok;
    logic                w_q_full;
    logic                w_tok_valid;
    logic                w_tok;
    logic                w_pop;

    rdft_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_valid  (s_axis_tvalid),
        .o_s_ready  (s_axis_tready),
        .i_s_data   (s_axis_tdata),
        .i_q_full   (w_q_full),
        .o_wr       (w_wr),
        .o_push     (w_push),
        .o_push_tok (w_push_tok)
    );

    rdft_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_tok (w_push_tok),
        .o_full     (w_q_full),
        .o_valid    (w_tok_valid),
        .o_head     (w_tok),
        .i_pop      (w_pop)
    );

    rdft_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr.en),
        .i_wr_addr (w_wr.addr),
        .i_wr_data (w_wr.data),
        .i_rd_en   (w_rd.en),
        .i_rd_addr (w_rd.addr),
        .o_rd_data (w_rd_data)
    );

    rdft_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (w_tok_valid),
        .i_tok       (w_tok),
        .o_tok_pop   (w_pop),
        .o_rd        (w_rd),
        .i_rd_data   (w_rd_data),
        .o_m_valid   (m_axis_tvalid),
        .i_m_ready   (m_axis_tready),
        .o_m_data    (m_axis_tdata),
        .o_m_bin     (m_axis_tuser),
        .o_m_last    (m_axis_tlast)
    );

`ifndef SYNTH
    // A finished frame always finds a free queue slot
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("frame token pushed into a full queue");

    // The engine releases only a bank it holds
    a_pop_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_tok_valid)
        else $error("frame token released from an empty queue");

    // Loading and transforming never touch the same bank in one cycle
    a_bank_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr.en && w_rd.en) |-> (w_wr.addr[ADDR_W-1] != w_rd.addr[ADDR_W-1]))
        else $error("sample write into the bank under transform");

    // Bin 0 follows the last bin of a frame once it is taken
    a_bin_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) ##1 m_axis_tvalid
        |-> (m_axis_tuser == '0) || !$changed(m_axis_tuser))
        else $error("frame did not restart at bin zero");
`endif

endmodule

// File: sim/tb_real_dft_engine.sv
// Self-checking testbench for real_dft_engine: streams frames of 64 signed samples
// and compares every returned bin against an in-bench fixed-point DFT predictor.
// Depends on rdft_pkg and the real_dft_engine RTL.
`timescale 1ns / 1ps

module tb_real_dft_engine;
    import rdft_pkg::*;

    // Fixed-point angle constants (Q2.30) and output scaling
    localparam longint ANGLE_PI  = 64'sd3373259426;
    localparam longint ANGLE_ONE = 64'sd1073741824;
    localparam int     BIN_SHIFT = $clog2(FRAME_LENGTH) + 15;

    localparam int     HOLD_OFF_CYCLES = 10000;
    localparam int     DRAIN_CYCLES    = 150;
    localparam int     NUM_RANDOM      = 2;
    localparam longint LIMIT_NS        = 64'd12_000_000;

    typedef enum logic [2:0] {
        FR_ZERO,
        FR_DC,
        FR_ALT,
        FR_IMPULSE,
        FR_RAMP,
        FR_NOISE,
        FR_QUIET,
        FR_RAILS
    } t_frame_kind;

    // One directed frame; bin 0 is typed in where it is obvious
    typedef struct packed {
        t_frame_kind        kind;
        logic signed [15:0] level;
        logic               typed;
        logic signed [15:0] dc_re;
        logic signed [15:0] dc_im;
    } t_frame_row;

    typedef struct packed {
        logic [IDX_W-1:0]   bin;
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic               last;
    } t_bin_result;

    localparam int NUM_DIRECTED = 2;
    localparam t_frame_row DIRECTED [0:NUM_DIRECTED-1] = '{
        '{FR_DC,      16'sd32767,  1'b1, 16'sd32766,  16'sd0},
        '{FR_IMPULSE, -16'sd32768, 1'b1, -16'sd512,   16'sd0}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [SAMPLE_W-1:0]   s_axis_tdata;    // [15:0] sample
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;    // [15:0] real_part, [31:16] imag_part
    logic [IDX_W-1:0]      m_axis_tuser;    // [5:0] bin_index
    logic                  m_axis_tlast;

    longint             cos_q15 [FRAME_LENGTH];
    longint             sin_q15 [FRAME_LENGTH];
    logic signed [15:0] frame_buf [FRAME_LENGTH];
    int                 frame_fill = 0;
    int                 out_frame = 0;
    t_bin_result        spectrum_q [$];
    int                 fail_count = 0;
    bit                 calm = 1'b0;
    bit                 hold_pending = 1'b0;

    real_dft_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic note_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    // Round Q30 to Q1.15 with halves upward, then clamp
    function automatic longint to_q15(input longint v);
        longint r;
        r = (v + 64'sd16384) >>> 15;
        if (r > 32767) begin
            r = 32767;
        end else if (r < -32768) begin
            r = -32768;
        end
        return r;
    endfunction

    // Twiddles over one turn: Taylor series on the first quadrant, then fold
    function automatic void build_twiddles();
        longint quarter;
        longint frac;
        longint ang;
        longint ang2;
        longint s_term;
        longint c_term;
        longint s_sum;
        longint c_sum;
        longint c15;
        longint s15;
        for (int m = 0; m < FRAME_LENGTH; m++) begin
            quarter = (4 * longint'(m) / FRAME_LENGTH) % 4;
            frac    = (4 * longint'(m)) % FRAME_LENGTH;
            ang     = (frac * ANGLE_PI + FRAME_LENGTH) / (2 * FRAME_LENGTH);
            ang2    = (ang * ang) >>> 30;
            s_term  = ang;
            s_sum   = ang;
            c_term  = ANGLE_ONE;
            c_sum   = ANGLE_ONE;
            for (int i = 1; i <= 8; i++) begin
                s_term = ((s_term * ang2) >>> 30) / longint'((2 * i) * (2 * i + 1));
                c_term = ((c_term * ang2) >>> 30) / longint'((2 * i - 1) * (2 * i));
                s_sum  = (i % 2 == 1) ? s_sum - s_term : s_sum + s_term;
                c_sum  = (i % 2 == 1) ? c_sum - c_term : c_sum + c_term;
            end
            c15 = to_q15(c_sum);
            s15 = to_q15(s_sum);
            case (quarter)
                0: begin
                    cos_q15[m] = c15;
                    sin_q15[m] = s15;
                end
                1: begin
                    cos_q15[m] = -s15;
                    sin_q15[m] = c15;
                end
                2: begin
                    cos_q15[m] = -c15;
                    sin_q15[m] = -s15;
                end
                default: begin
                    cos_q15[m] = s15;
                    sin_q15[m] = -c15;
                end
            endcase
        end
    endfunction

    // Divide by N * 2^15 toward minus infinity, clamp to 16 bits
    function automatic logic signed [15:0] scale_bin(input longint acc);
        longint q;
        q = acc >>> BIN_SHIFT;
        if (q > 32767) begin
            q = 32767;
        end else if (q < -32768) begin
            q = -32768;
        end
        return 16'(q);
    endfunction

    // Full frame held: work out every bin and queue it
    function automatic void predict_spectrum();
        longint      re_acc;
        longint      im_acc;
        longint      x;
        t_bin_result r;
        for (int k = 0; k < FRAME_LENGTH; k++) begin
            re_acc = 0;
            im_acc = 0;
            for (int n = 0; n < FRAME_LENGTH; n++) begin
                x      = longint'(frame_buf[n]);
                re_acc = re_acc + x * cos_q15[(k * n) % FRAME_LENGTH];
                im_acc = im_acc - x * sin_q15[(k * n) % FRAME_LENGTH];
            end
            r.bin  = IDX_W'(k);
            r.re   = scale_bin(re_acc);
            r.im   = scale_bin(im_acc);
            r.last = (k == FRAME_LENGTH - 1);
            spectrum_q.push_back(r);
        end
    endfunction

    function automatic logic [15:0] frame_sample(input t_frame_kind kind,
                                                 input logic signed [15:0] level,
                                                 input int n);
        logic [15:0] v;
        case (kind)
            FR_ZERO:    v = 16'd0;
            FR_DC:      v = level;
            FR_ALT:     v = (n % 2 == 0) ? 16'h7fff : 16'h8000;
            FR_IMPULSE: v = (n == 0) ? level : 16'd0;
            FR_RAMP:    v = 16'(-32768 + n * 1040);
            FR_QUIET:   v = 16'($signed($urandom_range(0, 512)) - 256);
            FR_RAILS: begin
                case ($urandom_range(0, 3))
                    0:       v = 16'h7fff;
                    1:       v = 16'h8000;
                    2:       v = 16'd0;
                    default: v = 16'($urandom_range(0, 65535));
                endcase
            end
            default:    v = 16'($urandom_range(0, 65535));
        endcase
        return v;
    endfunction

    // Offer one sample, with an occasional idle burst ahead of it
    task automatic send_sample(input logic [15:0] v);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = v;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic check_bin();
        t_bin_result        want;
        logic signed [15:0] got_re;
        logic signed [15:0] got_im;
        got_re = m_axis_tdata[15:0];
        got_im = m_axis_tdata[31:16];
        if (spectrum_q.size() == 0) begin
            note_mismatch($sformatf("unexpected bin %0d re %0d im %0d",
                                    m_axis_tuser, got_re, got_im));
            return;
        end
        want = spectrum_q.pop_front();
        if (m_axis_tuser !== want.bin) begin
            note_mismatch($sformatf("bin index %0d, want %0d", m_axis_tuser, want.bin));
        end
        if (got_re !== want.re) begin
            note_mismatch($sformatf("frame %0d bin %0d real %0d, want %0d",
                                    out_frame, want.bin, got_re, want.re));
        end
        if (got_im !== want.im) begin
            note_mismatch($sformatf("frame %0d bin %0d imag %0d, want %0d",
                                    out_frame, want.bin, got_im, want.im));
        end
        if (m_axis_tlast !== want.last) begin
            note_mismatch($sformatf("frame %0d bin %0d last %0b, want %0b",
                                    out_frame, want.bin, m_axis_tlast, want.last));
        end
        // Bin 0 of the hand-worked frames
        if (want.bin == 0 && out_frame < NUM_DIRECTED && DIRECTED[out_frame].typed) begin
            if (got_re !== DIRECTED[out_frame].dc_re || got_im !== DIRECTED[out_frame].dc_im)
            begin
                note_mismatch($sformatf("frame %0d dc (%0d,%0d), worked value (%0d,%0d)",
                                        out_frame, got_re, got_im,
                                        DIRECTED[out_frame].dc_re,
                                        DIRECTED[out_frame].dc_im));
            end
        end
        if (m_axis_tlast) begin
            out_frame++;
        end
    endtask

    // Capture accepted samples and returned bins
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            frame_buf[frame_fill] = s_axis_tdata;
            if (frame_fill == FRAME_LENGTH - 1) begin
                predict_spectrum();
                frame_fill = 0;
            end else begin
                frame_fill++;
            end
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            check_bin();
        end
    end

    // Result side: random stall bursts, one long hold-off, none at the end
    initial begin : sink_drive
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                m_axis_tready = 1'b0;
                stall_left--;
            end else if (hold_pending) begin
                hold_pending  = 1'b0;
                m_axis_tready = 1'b0;
                stall_left    = HOLD_OFF_CYCLES - 1;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                m_axis_tready = 1'b0;
                stall_left    = $urandom_range(1, 8) - 1;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    initial begin : watchdog
        #LIMIT_NS;
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        t_frame_kind        kind;
        logic signed [15:0] level;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        build_twiddles();
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed frames: top rail as DC, impulse at the bottom rail
        for (int row = 0; row < NUM_DIRECTED; row++) begin
            for (int n = 0; n < FRAME_LENGTH; n++) begin
                send_sample(frame_sample(DIRECTED[row].kind, DIRECTED[row].level, n));
            end
        end

        // Random frames; hold the result side off so the store fills up
        hold_pending = 1'b1;
        for (int f = 0; f < NUM_RANDOM; f++) begin
            if (f == NUM_RANDOM - 1) begin
                calm = 1'b1;
            end
            case ($urandom_range(0, 3))
                0:       kind = FR_QUIET;
                1:       kind = FR_RAILS;
                default: kind = FR_NOISE;
            endcase
            level = 16'sd0;
            for (int n = 0; n < FRAME_LENGTH; n++) begin
                send_sample(frame_sample(kind, level, n));
            end
        end
        s_axis_tvalid = 1'b0;

        // Let the backlog drain, then watch for stray results
        while (spectrum_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
